@@ sv/bhtlp_pkg.sv @@
// shared types, codes and helpers for the bucketed hash table
`default_nettype none

package bhtlp_pkg;

    // field widths of a command transfer
    localparam int KEY_W    = 27;
    localparam int CMD_W    = 2;
    localparam int RES_W    = 3;
    localparam int STAT_W   = 2;
    localparam int TS_W     = 32;

    // key is folded modulo the bucket count one byte per cycle
    localparam int CHUNK_W  = 8;
    localparam int NCHUNK   = (KEY_W + CHUNK_W - 1) / CHUNK_W;
    localparam int KEYPAD_W = NCHUNK * CHUNK_W;
    localparam int CHCNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    localparam logic [KEY_W-1:0] KEY_MIN = KEY_W'(10000000);
    localparam logic [KEY_W-1:0] KEY_MAX = KEY_W'(99999999);

    // commands
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd3;

    // result codes
    localparam logic [RES_W-1:0] RES_OK        = 3'd0;
    localparam logic [RES_W-1:0] RES_NOT_FOUND = 3'd1;
    localparam logic [RES_W-1:0] RES_FULL      = 3'd2;
    localparam logic [RES_W-1:0] RES_DUP       = 3'd3;
    localparam logic [RES_W-1:0] RES_BAD_KEY   = 3'd4;

    // slot status
    localparam logic [STAT_W-1:0] ST_FREE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_ACTIVE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_DELETED = 2'd2;

    // one slot of the tag memory
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [KEY_W-1:0]  key;
    } slot_tag_t;

    // record payload kept per slot
    typedef struct packed {
        logic [63:0]     plate_head;
        logic [15:0]     plate_tail;
        logic [TS_W-1:0] timestamp;
        logic [31:0]     gate;
        logic [16:0]     amount;
    } record_t;

    // day, month, year, hour, minute packed from the top bit down
    function automatic logic [TS_W-1:0] pack_time(
        input logic [4:0]  day,
        input logic [3:0]  month,
        input logic [11:0] year,
        input logic [4:0]  hour,
        input logic [5:0]  minute
    );
        pack_time = {day, month, year, hour, minute};
    endfunction

endpackage

`default_nettype wire

@@ sv/bucket_hash_table_linear_probe.sv @@
// bucketed hash table with linear probing over a bucket-wide tag memory
// flow: the input transfer is captured, then the key is folded into its home bucket over NCHUNK (4) byte chunks,
//   then the probe walk (skipped for a bad insert key) reads the rows along the path
//   with one row read per cycle pipelined against the previous row's evaluation, then a write-back
// commands: one at a time; a new command is taken only after the previous write-back, which
//   waits while the result register holds a result that has not been taken
// reset: rst_n is asynchronous and active low; every row valid bit clears so all
//   slots read as free; record contents are not cleared and need no sweep
`default_nettype none

module bucket_hash_table_linear_probe #(
    parameter int BUCKETS    = 8,
    parameter int SLOTS      = 3,
    parameter int PROBE_STEP = 1
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [bhtlp_pkg::CMD_W-1:0]        cmd,
    input  wire logic [bhtlp_pkg::KEY_W-1:0]        key,
    input  wire logic [63:0]                        plate_head,
    input  wire logic [15:0]                        plate_tail,
    input  wire logic [4:0]                         day,
    input  wire logic [3:0]                         month,
    input  wire logic [11:0]                        year,
    input  wire logic [4:0]                         hour,
    input  wire logic [5:0]                         minute,
    input  wire logic [31:0]                        gate_code,
    input  wire logic [16:0]                        amount,

    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [bhtlp_pkg::RES_W-1:0]             result_code,
    output logic [$clog2(BUCKETS+1)-1:0]            bucket_index,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] slot_index,
    output logic                                    overflowed
);

    import bhtlp_pkg::*;

    // derived sizes
    localparam int BW        = $clog2(BUCKETS);
    localparam int BO_W      = $clog2(BUCKETS+1);
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NENT      = BUCKETS * SLOTS;
    localparam int EA_W      = (NENT > 1) ? $clog2(NENT) : 1;
    localparam int STEP_MOD  = PROBE_STEP % BUCKETS;

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MOD   = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    typedef slot_tag_t [SLOTS-1:0] tag_row_t;

    // storage: tag rows (status and key per slot) and per-slot records
    tag_row_t tag_mem [BUCKETS];
    record_t  rec_mem [NENT];

    // control
    logic [1:0]          state_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [KEY_W-1:0]    key_reg;
    record_t             rec_reg;
    logic [CHCNT_W-1:0]  chunk_reg;
    logic [BW-1:0]       rem_reg;
    logic [BW-1:0]       rem_next;
    logic [BW-1:0]       home_reg;

    // probe issue side
    logic [BW-1:0]       issue_b_reg;
    logic [BW-1:0]       issue_b_next;
    logic                issue_on_reg;
    logic                rd_en;

    // probe evaluation side (in the cycle after the read)
    logic                rd_vld_reg;
    logic [BW-1:0]       rd_b_reg;
    logic                rd_last_reg;
    tag_row_t            rd_row_reg;
    logic                rd_rowok_reg;
    logic [BUCKETS-1:0]  row_valid_reg;
    logic                probe_end;

    // target slot found while probing
    logic                free_ok_reg;
    logic [BW-1:0]       tgt_b_reg;
    logic [SLOT_W-1:0]   tgt_s_reg;
    tag_row_t            tgt_row_reg;
    logic [RES_W-1:0]    code_reg;

    // result register
    logic                out_valid_reg;
    logic [RES_W-1:0]    res_code_reg;
    logic [BO_W-1:0]     res_bucket_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic                res_ovf_reg;

    // row evaluation
    tag_row_t            row_eff;
    logic                hit;
    logic [SLOT_W-1:0]   hit_s;
    logic                has_free;
    logic [SLOT_W-1:0]   free_s;

    // write-back
    logic                wb_fire;
    logic                wb_ok;
    logic                tag_we;
    tag_row_t            tag_wdata;
    logic [EA_W-1:0]     ent_addr;
    logic                key_bad;
    logic [KEYPAD_W-1:0] key_pad;

    assign in_ready = (state_reg == S_IDLE);

    // fold one byte of the key into the running remainder, msb first
    assign key_pad = KEYPAD_W'(key_reg);

    always_comb
    begin
        logic [BW:0]          r;
        logic [CHUNK_W-1:0]   chunk;
        chunk = key_pad[(NCHUNK - 1 - int'(chunk_reg)) * CHUNK_W +: CHUNK_W];
        r = {1'b0, rem_reg};
        for (int i = CHUNK_W - 1; i >= 0; i--)
        begin
            r = {r[BW-1:0], chunk[i]};
            if (r >= (BW+1)'(BUCKETS))
            begin
                r = r - (BW+1)'(BUCKETS);
            end
        end
        rem_next = r[BW-1:0];
    end

    assign key_bad = (key_reg < KEY_MIN) || (key_reg > KEY_MAX);

    // next bucket on the probe path, wrapping inside the table
    always_comb
    begin
        logic [BW:0] s;
        s = {1'b0, issue_b_reg} + (BW+1)'(STEP_MOD);
        if (s >= (BW+1)'(BUCKETS))
        begin
            s = s - (BW+1)'(BUCKETS);
        end
        issue_b_next = s[BW-1:0];
    end

    assign rd_en = (state_reg == S_PROBE) && issue_on_reg;

    // a row never written reads as all free
    assign row_eff = rd_rowok_reg ? rd_row_reg : '0;

    // lowest matching active slot and lowest free slot of the row
    always_comb
    begin
        hit      = 1'b0;
        hit_s    = '0;
        has_free = 1'b0;
        free_s   = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (row_eff[s].status == ST_ACTIVE && row_eff[s].key == key_reg)
            begin
                hit   = 1'b1;
                hit_s = SLOT_W'(s);
            end
            if (row_eff[s].status == ST_FREE)
            begin
                has_free = 1'b1;
                free_s   = SLOT_W'(s);
            end
        end
    end

    // the walk stops on a live match or after the last row of the path
    assign probe_end = (state_reg == S_PROBE) && rd_vld_reg && (hit || rd_last_reg);

    // write-back happens once the result register can take the result
    assign wb_fire = (state_reg == S_WRITE) && (!out_valid_reg || out_ready);
    assign wb_ok   = (code_reg == RES_OK);
    assign tag_we  = wb_fire && wb_ok && (cmd_reg == CMD_INSERT || cmd_reg == CMD_DELETE);
    assign ent_addr = EA_W'(tgt_b_reg) * EA_W'(SLOTS) + EA_W'(tgt_s_reg);

    always_comb
    begin
        tag_wdata = tgt_row_reg;
        if (cmd_reg == CMD_INSERT)
        begin
            tag_wdata[tgt_s_reg].status = ST_ACTIVE;
            tag_wdata[tgt_s_reg].key    = key_reg;
        end
        else
        begin
            tag_wdata[tgt_s_reg].status = ST_DELETED;
        end
    end

    // tag memory: one read port for probing, one write port for write-back
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_reg <= tag_mem[issue_b_reg];
        end
        if (tag_we)
        begin
            tag_mem[tgt_b_reg] <= tag_wdata;
        end
    end

    // record memory: full record on insert, timestamp only on update
    always_ff @(posedge clk)
    begin
        if (wb_fire && wb_ok && cmd_reg == CMD_INSERT)
        begin
            rec_mem[ent_addr] <= rec_reg;
        end
        else if (wb_fire && wb_ok && cmd_reg == CMD_UPDATE)
        begin
            rec_mem[ent_addr].timestamp <= rec_reg.timestamp;
        end
    end

    // payload captured on the input transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg              <= cmd;
            key_reg              <= key;
            rec_reg.plate_head   <= plate_head;
            rec_reg.plate_tail   <= plate_tail;
            rec_reg.timestamp    <= pack_time(day, month, year, hour, minute);
            rec_reg.gate         <= gate_code;
            rec_reg.amount       <= amount;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            chunk_reg      <= '0;
            rem_reg        <= '0;
            home_reg       <= '0;
            issue_b_reg    <= '0;
            issue_on_reg   <= 1'b0;
            rd_vld_reg     <= 1'b0;
            rd_b_reg       <= '0;
            rd_last_reg    <= 1'b0;
            rd_rowok_reg   <= 1'b0;
            row_valid_reg  <= '0;
            free_ok_reg    <= 1'b0;
            tgt_b_reg      <= '0;
            tgt_s_reg      <= '0;
            tgt_row_reg    <= '0;
            code_reg       <= RES_OK;
            out_valid_reg  <= 1'b0;
            res_code_reg   <= RES_OK;
            res_bucket_reg <= '0;
            res_slot_reg   <= '0;
            res_ovf_reg    <= 1'b0;
        end
        else
        begin
            // a result taken while a new one is written stays valid
            if (out_valid_reg && out_ready && !wb_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            // read pipeline runs alongside the issue side; a read in flight
            // when the walk stops is dropped
            rd_vld_reg <= rd_en && !probe_end;
            if (rd_en)
            begin
                rd_b_reg     <= issue_b_reg;
                rd_last_reg  <= (issue_b_next == home_reg);
                rd_rowok_reg <= row_valid_reg[issue_b_reg];
                issue_b_reg  <= issue_b_next;
                issue_on_reg <= (issue_b_next != home_reg) && !probe_end;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_MOD;
                        chunk_reg <= '0;
                        rem_reg   <= '0;
                    end
                end

                S_MOD:
                begin
                    rem_reg   <= rem_next;
                    chunk_reg <= chunk_reg + 1'b1;
                    if (chunk_reg == CHCNT_W'(NCHUNK - 1))
                    begin
                        home_reg     <= rem_next;
                        issue_b_reg  <= rem_next;
                        free_ok_reg  <= 1'b0;
                        if (cmd_reg == CMD_INSERT && key_bad)
                        begin
                            code_reg  <= RES_BAD_KEY;
                            state_reg <= S_WRITE;
                        end
                        else
                        begin
                            issue_on_reg <= 1'b1;
                            state_reg    <= S_PROBE;
                        end
                    end
                end

                S_PROBE:
                begin
                    if (rd_vld_reg)
                    begin
                        if (hit)
                        begin
                            // a live match ends the walk: duplicate for insert
                            code_reg     <= (cmd_reg == CMD_INSERT) ? RES_DUP : RES_OK;
                            tgt_b_reg    <= rd_b_reg;
                            tgt_s_reg    <= hit_s;
                            tgt_row_reg  <= row_eff;
                            state_reg    <= S_WRITE;
                        end
                        else
                        begin
                            // remember the first free slot along the path
                            if (cmd_reg == CMD_INSERT && has_free && !free_ok_reg)
                            begin
                                free_ok_reg <= 1'b1;
                                tgt_b_reg   <= rd_b_reg;
                                tgt_s_reg   <= free_s;
                                tgt_row_reg <= row_eff;
                            end
                            if (rd_last_reg)
                            begin
                                if (cmd_reg == CMD_INSERT)
                                begin
                                    code_reg <= (free_ok_reg || has_free) ? RES_OK : RES_FULL;
                                end
                                else
                                begin
                                    code_reg <= RES_NOT_FOUND;
                                end
                                state_reg    <= S_WRITE;
                            end
                        end
                    end
                end

                S_WRITE:
                begin
                    if (wb_fire)
                    begin
                        out_valid_reg <= 1'b1;
                        res_code_reg  <= code_reg;
                        if (wb_ok)
                        begin
                            res_bucket_reg <= BO_W'(tgt_b_reg) + BO_W'(1);
                            res_slot_reg   <= tgt_s_reg;
                            res_ovf_reg    <= (cmd_reg == CMD_INSERT) && (tgt_b_reg != home_reg);
                        end
                        else
                        begin
                            res_bucket_reg <= '0;
                            res_slot_reg   <= '0;
                            res_ovf_reg    <= 1'b0;
                        end
                        if (tag_we)
                        begin
                            row_valid_reg[tgt_b_reg] <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_code  = res_code_reg;
    assign bucket_index = res_bucket_reg;
    assign slot_index   = res_slot_reg;
    assign overflowed   = res_ovf_reg;

    // a successful result always names a bucket inside the table
    a_ok_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_code == RES_OK |->
            bucket_index != '0 && bucket_index <= BO_W'(BUCKETS))
        else $error("ok result with bucket outside the table");

    // a failed command reports no location and no overflow
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_code != RES_OK |->
            bucket_index == '0 && slot_index == '0 && !overflowed)
        else $error("failed command reports a location");

    // the tag memory is written only while the result is being produced
    a_tag_write_at_result: assert property (@(posedge clk) disable iff (!rst_n)
        tag_we |=> out_valid && result_code == RES_OK)
        else $error("tag write without a matching ok result");

    // no row is read outside the probe walk
    a_read_in_probe: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(state_reg) == S_PROBE)
        else $error("tag row read outside probing");

endmodule

`default_nettype wire
